FILE: design/fhsa_pkg.sv
// fhsa_pkg: shared types and constants for the free hole segment allocator
// holds payload structs, controller/datapath command and status structs, codes
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fhsa_pkg;

    // field widths
    localparam int AW = 20;            // release base address bits
    localparam int VW = AW + 1;        // size, length and address value bits
    localparam int CFG_IDX_W = 2;

    // action codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_COMPACT = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FRAG    = 2'd1;
    localparam logic [1:0] STS_NOSPACE = 2'd2;
    localparam logic [1:0] STS_OVF     = 2'd3;

    // fit policies, any other code acts as first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_SIZE = 2'd2;

    localparam logic [VW-1:0] MEM_SIZE_RST = 21'd4096;
    localparam logic [VW-1:0] RSV_SIZE_RST = 21'd128;

    // request beat
    typedef struct packed {
        logic [1:0]    action;
        logic [AW-1:0] seg_base;
        logic [VW-1:0] seg_size;
    } t_req;

    // result beat
    typedef struct packed {
        logic [1:0]    status;
        logic [VW-1:0] result_base;
    } t_rsp;

    // controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_WR1,
        S_MOVE,
        S_MDRAIN,
        S_WR2,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic init;
        logic latch;
        logic scan_step;
        logic decide;
        logic wr1;
        logic move_step;
        logic wr2;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic move_last;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: design/fhsa_ctrl.sv
// fhsa_ctrl: sequencing state machine of the allocator
// drives datapath commands from its state; depends on fhsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fhsa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  fhsa_pkg::t_dp_sts     i_sts,
    output fhsa_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    fhsa_pkg::t_state r_state;
    fhsa_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fhsa_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fhsa_pkg::S_INIT:   n_state = fhsa_pkg::S_IDLE;
            fhsa_pkg::S_IDLE:   if (i_start) n_state = fhsa_pkg::S_SCAN;
            fhsa_pkg::S_SCAN:   if (i_sts.scan_last) n_state = fhsa_pkg::S_DRAIN;
            fhsa_pkg::S_DRAIN:  n_state = fhsa_pkg::S_DECIDE;
            fhsa_pkg::S_DECIDE: n_state = fhsa_pkg::S_WR1;
            fhsa_pkg::S_WR1:    n_state = fhsa_pkg::S_MOVE;
            fhsa_pkg::S_MOVE:   if (i_sts.move_last) n_state = fhsa_pkg::S_MDRAIN;
            fhsa_pkg::S_MDRAIN: n_state = fhsa_pkg::S_WR2;
            fhsa_pkg::S_WR2:    n_state = fhsa_pkg::S_DONE;
            fhsa_pkg::S_DONE:   n_state = fhsa_pkg::S_IDLE;
            default:            n_state = fhsa_pkg::S_INIT;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.init      = (r_state == fhsa_pkg::S_INIT);
        o_cmd.latch     = (r_state == fhsa_pkg::S_IDLE) && i_start;
        o_cmd.scan_step = (r_state == fhsa_pkg::S_SCAN);
        o_cmd.decide    = (r_state == fhsa_pkg::S_DECIDE);
        o_cmd.wr1       = (r_state == fhsa_pkg::S_WR1);
        o_cmd.move_step = (r_state == fhsa_pkg::S_MOVE);
        o_cmd.wr2       = (r_state == fhsa_pkg::S_WR2);
        o_busy          = (r_state != fhsa_pkg::S_IDLE);
        o_done          = (r_state == fhsa_pkg::S_DONE);
    end

    // a result beat is single and the block is free right after it
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !o_busy))
        else $error("result strobe not followed by idle");

endmodule

`default_nettype wire

FILE: design/fhsa_dp.sv
// fhsa_dp: hole table memory, config registers, scan accumulators, move engine
// follows fhsa_ctrl commands; depends on fhsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fhsa_dp #(
    parameter int MAX_HOLES = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  fhsa_pkg::t_dp_cmd                      i_cmd,
    output fhsa_pkg::t_dp_sts                      o_sts,
    input  fhsa_pkg::t_req                         i_req,
    output fhsa_pkg::t_rsp                         o_rsp,
    input  wire logic                              i_cfg_we,
    input  wire logic [fhsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fhsa_pkg::VW-1:0]           i_cfg_data
);

    localparam int VW = fhsa_pkg::VW;
    localparam int AW = fhsa_pkg::AW;
    localparam int IW = $clog2(MAX_HOLES);
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int SW = VW + CW;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_HOLES);

    // config registers
    logic [1:0]    r_policy;
    logic [VW-1:0] r_mem_size;
    logic [VW-1:0] r_rsv_size;

    // latched request
    logic [1:0]    r_action;
    logic [AW-1:0] r_base;
    logic [VW-1:0] r_size;

    // table
    logic [2*VW-1:0] mem [MAX_HOLES];
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic [2*VW-1:0] r_rdata;
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;

    // scan accumulators
    logic [SW-1:0] r_sum;
    logic          r_hpick;
    logic [IW-1:0] r_pick;
    logic [VW-1:0] r_pstart;
    logic [VW-1:0] r_plen;
    logic          r_hl;
    logic [IW-1:0] r_left;
    logic [VW-1:0] r_lstart;
    logic [VW-1:0] r_llen;
    logic          r_hr;
    logic [IW-1:0] r_right;
    logic [VW-1:0] r_rlen;
    logic          r_hpos;
    logic [CW-1:0] r_pos;

    // update plan
    logic            r_wr1_en,   n_wr1_en;
    logic [IW-1:0]   r_wr1_addr, n_wr1_addr;
    logic [2*VW-1:0] r_wr1_data, n_wr1_data;
    logic            r_wr2_en,   n_wr2_en;
    logic [IW-1:0]   r_wr2_addr, n_wr2_addr;
    logic [2*VW-1:0] r_wr2_data, n_wr2_data;
    logic [CW-1:0]   n_mv_rem;
    logic [IW-1:0]   n_mv_src;
    logic            n_mv_up;
    logic [CW-1:0]   n_count;
    logic [1:0]      r_status,   n_status;
    logic [VW-1:0]   r_res_base, n_res_base;

    // move engine
    logic [CW-1:0] r_mv_rem;
    logic [IW-1:0] r_mv_src;
    logic          r_mv_up;
    logic          r_mv_pv;
    logic [IW-1:0] r_mv_dst;

    // rebuild on region writes or after reset
    logic [VW-1:0] nm, nr;
    logic          rebuild;
    always_comb begin
        nm = (i_cfg_we && i_cfg_idx == fhsa_pkg::CFG_MEM_SIZE) ? i_cfg_data : r_mem_size;
        nr = (i_cfg_we && i_cfg_idx == fhsa_pkg::CFG_RSV_SIZE) ? i_cfg_data : r_rsv_size;
        rebuild = i_cmd.init || (i_cfg_we && (i_cfg_idx == fhsa_pkg::CFG_MEM_SIZE ||
                                              i_cfg_idx == fhsa_pkg::CFG_RSV_SIZE));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= fhsa_pkg::POL_FIRST;
            r_mem_size <= fhsa_pkg::MEM_SIZE_RST;
            r_rsv_size <= fhsa_pkg::RSV_SIZE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fhsa_pkg::CFG_POLICY) r_policy <= i_cfg_data[1:0];
            r_mem_size <= nm;
            r_rsv_size <= nr;
        end
    end

    // read port: scan or move source
    logic          scan_rd, move_rd;
    logic [IW-1:0] rd_addr;
    always_comb begin
        scan_rd = i_cmd.scan_step && (r_idx < r_count);
        move_rd = i_cmd.move_step && (r_mv_rem != '0);
        rd_addr = scan_rd ? r_idx[IW-1:0] : r_mv_src;
    end

    // write port, one source per cycle
    logic            we;
    logic [IW-1:0]   wr_addr;
    logic [2*VW-1:0] wr_data;
    always_comb begin
        we      = 1'b0;
        wr_addr = '0;
        wr_data = {nr, nm - nr};
        priority if (rebuild) begin
            we = (nm > nr);
        end else if (r_mv_pv) begin
            we      = 1'b1;
            wr_addr = r_mv_dst;
            wr_data = r_rdata;
        end else if (i_cmd.wr1) begin
            we      = r_wr1_en;
            wr_addr = r_wr1_addr;
            wr_data = r_wr1_data;
        end else if (i_cmd.wr2) begin
            we      = r_wr2_en;
            wr_addr = r_wr2_addr;
            wr_data = r_wr2_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (scan_rd || move_rd) r_rdata <= mem[rd_addr];
    end

    // status to controller
    always_comb begin
        o_sts.scan_last = (r_count == '0) ||
                          (({1'b0, r_idx} + (CW+1)'(1)) >= {1'b0, r_count});
        o_sts.move_last = (r_mv_rem <= CW'(1));
    end

    // scanned entry
    logic [VW-1:0] rd_start, rd_len;
    logic [VW:0]   rd_end, rel_end;
    logic          fit, take;
    always_comb begin
        rd_start = r_rdata[2*VW-1:VW];
        rd_len   = r_rdata[VW-1:0];
        rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
        rel_end  = (VW+1)'(r_base) + {1'b0, r_size};
        fit      = (rd_len >= r_size);
        take     = 1'b0;
        if (fit) begin
            priority if (!r_hpick) take = 1'b1;
            else if (r_policy == fhsa_pkg::POL_BEST)  take = (rd_len < r_plen);
            else if (r_policy == fhsa_pkg::POL_WORST) take = (rd_len > r_plen);
        end
    end

    // request latch and scan accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
            r_hpick  <= 1'b0;
            r_hl     <= 1'b0;
            r_hr     <= 1'b0;
            r_hpos   <= 1'b0;
        end else begin
            r_rd_vld <= scan_rd;
            r_rd_idx <= r_idx[IW-1:0];
            if (i_cmd.latch) begin
                r_action <= i_req.action;
                r_base   <= i_req.seg_base;
                r_size   <= i_req.seg_size;
                r_idx    <= '0;
                r_sum    <= '0;
                r_hpick  <= 1'b0;
                r_hl     <= 1'b0;
                r_hr     <= 1'b0;
                r_hpos   <= 1'b0;
                r_pos    <= r_count;
            end else if (scan_rd) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_rd_vld) begin
                r_sum <= r_sum + SW'(rd_len);
                if (take) begin
                    r_hpick  <= 1'b1;
                    r_pick   <= r_rd_idx;
                    r_pstart <= rd_start;
                    r_plen   <= rd_len;
                end
                if (!r_hl && rd_end == (VW+1)'(r_base)) begin
                    r_hl     <= 1'b1;
                    r_left   <= r_rd_idx;
                    r_lstart <= rd_start;
                    r_llen   <= rd_len;
                end
                if (!r_hr && {1'b0, rd_start} == rel_end) begin
                    r_hr    <= 1'b1;
                    r_right <= r_rd_idx;
                    r_rlen  <= rd_len;
                end
                if (!r_hpos && rd_start > VW'(r_base)) begin
                    r_hpos <= 1'b1;
                    r_pos  <= CW'(r_rd_idx);
                end
            end
        end
    end

    // update plan from scan results
    logic [SW-1:0] cmp_diff;
    always_comb begin
        n_wr1_en   = 1'b0;
        n_wr1_addr = '0;
        n_wr1_data = '0;
        n_wr2_en   = 1'b0;
        n_wr2_addr = r_pos[IW-1:0];
        n_wr2_data = {VW'(r_base), r_size};
        n_mv_rem   = '0;
        n_mv_src   = '0;
        n_mv_up    = 1'b0;
        n_count    = r_count;
        n_status   = fhsa_pkg::STS_OK;
        n_res_base = '0;
        cmp_diff   = SW'(r_mem_size) - r_sum;
        unique case (r_action)
            fhsa_pkg::ACT_ALLOC: begin
                if (r_hpick) begin
                    n_res_base = r_pstart;
                    if (r_plen > r_size) begin
                        n_wr1_en   = 1'b1;
                        n_wr1_addr = r_pick;
                        n_wr1_data = {r_pstart + r_size, r_plen - r_size};
                    end else if (r_size != '0) begin
                        // exact fit, close the gap
                        n_mv_src = r_pick + IW'(1);
                        n_mv_rem = r_count - CW'(r_pick) - CW'(1);
                        n_count  = r_count - CW'(1);
                    end
                end else begin
                    n_status = (r_sum >= SW'(r_size)) ? fhsa_pkg::STS_FRAG
                                                      : fhsa_pkg::STS_NOSPACE;
                end
            end
            fhsa_pkg::ACT_RELEASE: begin
                if (r_size != '0) begin
                    priority if (r_hl && r_hr) begin
                        n_wr1_en   = 1'b1;
                        n_wr1_addr = r_left;
                        n_wr1_data = {r_lstart, r_llen + r_size + r_rlen};
                        n_mv_src   = r_right + IW'(1);
                        n_mv_rem   = r_count - CW'(r_right) - CW'(1);
                        n_count    = r_count - CW'(1);
                    end else if (r_hl) begin
                        n_wr1_en   = 1'b1;
                        n_wr1_addr = r_left;
                        n_wr1_data = {r_lstart, r_llen + r_size};
                    end else if (r_hr) begin
                        n_wr1_en   = 1'b1;
                        n_wr1_addr = r_right;
                        n_wr1_data = {VW'(r_base), r_rlen + r_size};
                    end else if (r_count >= CNT_MAX) begin
                        n_status = fhsa_pkg::STS_OVF;
                    end else begin
                        // open a slot at the sorted position
                        n_mv_up  = 1'b1;
                        n_mv_src = IW'(r_count - CW'(1));
                        n_mv_rem = r_count - r_pos;
                        n_wr2_en = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
            end
            fhsa_pkg::ACT_COMPACT: begin
                n_res_base = (SW'(r_mem_size) >= r_sum) ? cmp_diff[VW-1:0] : '0;
                if (r_sum == '0) begin
                    n_count = '0;
                end else begin
                    n_wr1_en   = 1'b1;
                    n_wr1_data = {n_res_base, r_sum[VW-1:0]};
                    n_count    = CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // plan registers, count and move engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_mv_rem <= '0;
            r_mv_pv  <= 1'b0;
            r_wr1_en <= 1'b0;
            r_wr2_en <= 1'b0;
        end else begin
            if (rebuild) begin
                r_count <= (nm > nr) ? CW'(1) : '0;
            end else if (i_cmd.decide) begin
                r_count <= n_count;
            end
            if (i_cmd.decide) begin
                r_wr1_en   <= n_wr1_en;
                r_wr1_addr <= n_wr1_addr;
                r_wr1_data <= n_wr1_data;
                r_wr2_en   <= n_wr2_en;
                r_wr2_addr <= n_wr2_addr;
                r_wr2_data <= n_wr2_data;
                r_status   <= n_status;
                r_res_base <= n_res_base;
                r_mv_rem   <= n_mv_rem;
                r_mv_src   <= n_mv_src;
                r_mv_up    <= n_mv_up;
            end
            r_mv_pv <= move_rd;
            if (move_rd) begin
                r_mv_rem <= r_mv_rem - CW'(1);
                r_mv_dst <= r_mv_up ? r_mv_src + IW'(1) : r_mv_src - IW'(1);
                r_mv_src <= r_mv_up ? r_mv_src - IW'(1) : r_mv_src + IW'(1);
            end
        end
    end

    always_comb begin
        o_rsp.status      = r_status;
        o_rsp.result_base = r_res_base;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("hole count beyond table depth");

    a_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mv_pv && (i_cmd.wr1 || i_cmd.wr2 || rebuild)))
        else $error("move write collides with another write");

    a_scan_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.scan_step))
        else $error("scan data without scan read");

endmodule

`default_nettype wire

FILE: design/free_hole_segment_allocator_core.sv
// free_hole_segment_allocator_core: top level of the hole table allocator
// joins fhsa_ctrl and fhsa_dp; depends on fhsa_pkg
//
//   channel   handshake              payload
//   request   start & !busy          i_req  (action, seg_base, seg_size)
//   result    o_done, one cycle      o_rsp  (status, result_base)
//   config    i_cfg_we               i_cfg_idx, i_cfg_data
//
// an item makes one table read per hole through the single read port of the
// hole memory, then a shift pass that moves the later entries by one slot when
// a hole is removed or inserted
// after reset the first hole is rebuilt while busy is high
// results cannot be held off; o_rsp is valid only while o_done is high
`timescale 1ns / 1ps
`default_nettype none

module free_hole_segment_allocator_core #(
    parameter int MAX_HOLES = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  fhsa_pkg::t_req                      i_req,
    output logic                                o_done,
    output fhsa_pkg::t_rsp                      o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [fhsa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fhsa_pkg::VW-1:0]        i_cfg_data
);

    fhsa_pkg::t_dp_cmd cmd;
    fhsa_pkg::t_dp_sts sts;

    // sequencer
    fhsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // table and arithmetic
    fhsa_dp #(
        .MAX_HOLES (MAX_HOLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// tb: self-checking bench for free_hole_segment_allocator_core
// drives allocate, release and compact beats and checks each result beat against
// an in-bench model of the hole table; depends on fhsa_pkg and the core
`timescale 1ns / 1ps

module tb;

    localparam int NHOLES = 32;
    localparam int CYC_LIMIT = 900000;
    localparam int N_RANDOM = 1230;
    // action code with no operation behind it
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    fhsa_pkg::t_req i_req;
    logic o_done;
    fhsa_pkg::t_rsp o_rsp;
    logic i_cfg_we;
    logic [fhsa_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [fhsa_pkg::VW-1:0] i_cfg_data;

    free_hole_segment_allocator_core #(.MAX_HOLES(NHOLES)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_rsp(o_rsp), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // model of the hole table
    logic [fhsa_pkg::VW-1:0] tbl_base [NHOLES];
    logic [fhsa_pkg::VW-1:0] tbl_len [NHOLES];
    int unsigned tbl_cnt;
    logic [1:0] mdl_policy;
    logic [fhsa_pkg::VW-1:0] mdl_mem;
    logic [fhsa_pkg::VW-1:0] mdl_rsv;

    fhsa_pkg::t_req pending_req [$];
    fhsa_pkg::t_rsp expected_rsp [$];
    int errors;
    int n_checked;
    int cycles;
    bit gaps_on;

    function automatic void rebuild_table();
        for (int i = 0; i < NHOLES; i++) begin
            tbl_base[i] = '0;
            tbl_len[i] = '0;
        end
        if (mdl_mem > mdl_rsv) begin
            tbl_base[0] = mdl_rsv;
            tbl_len[0] = mdl_mem - mdl_rsv;
            tbl_cnt = 1;
        end else begin
            tbl_cnt = 0;
        end
    endfunction

    function automatic void drop_hole(int unsigned idx);
        for (int unsigned i = idx; i + 1 < tbl_cnt; i++) begin
            tbl_base[i] = tbl_base[i+1];
            tbl_len[i] = tbl_len[i+1];
        end
        tbl_cnt--;
        tbl_base[tbl_cnt] = '0;
        tbl_len[tbl_cnt] = '0;
    endfunction

    function automatic longint unsigned free_total();
        longint unsigned sum;
        sum = 0;
        for (int unsigned i = 0; i < tbl_cnt; i++) sum += tbl_len[i];
        return sum;
    endfunction

    // compute the result of one request and update the table
    function automatic fhsa_pkg::t_rsp apply_request(fhsa_pkg::t_req rq);
        fhsa_pkg::t_rsp r;
        int pick;
        int lft;
        int rgt;
        int unsigned pos;
        longint unsigned sz;
        longint unsigned b;
        longint unsigned f;
        r = '0;
        sz = rq.seg_size;
        b = rq.seg_base;
        case (rq.action)
            fhsa_pkg::ACT_ALLOC: begin
                pick = -1;
                for (int unsigned i = 0; i < tbl_cnt; i++) begin
                    if (tbl_len[i] < sz) continue;
                    if (pick < 0) pick = i;
                    else if (mdl_policy == fhsa_pkg::POL_BEST && tbl_len[i] < tbl_len[pick])
                        pick = i;
                    else if (mdl_policy == fhsa_pkg::POL_WORST && tbl_len[i] > tbl_len[pick])
                        pick = i;
                end
                if (pick < 0) begin
                    r.status = (free_total() >= sz) ? fhsa_pkg::STS_FRAG
                                                    : fhsa_pkg::STS_NOSPACE;
                end else begin
                    r.result_base = tbl_base[pick];
                    if (tbl_len[pick] > sz) begin
                        tbl_base[pick] = tbl_base[pick] + fhsa_pkg::VW'(sz);
                        tbl_len[pick] = tbl_len[pick] - fhsa_pkg::VW'(sz);
                    end else if (sz != 0) begin
                        drop_hole(pick);
                    end
                end
            end
            fhsa_pkg::ACT_RELEASE: begin
                if (sz != 0) begin
                    lft = -1;
                    rgt = -1;
                    for (int unsigned i = 0; i < tbl_cnt; i++) begin
                        if (lft < 0 && longint'(tbl_base[i]) + tbl_len[i] == b) lft = i;
                        if (rgt < 0 && tbl_base[i] == b + sz) rgt = i;
                    end
                    if (lft >= 0 && rgt >= 0) begin
                        tbl_len[lft] = fhsa_pkg::VW'(tbl_len[lft] + sz + tbl_len[rgt]);
                        drop_hole(rgt);
                    end else if (lft >= 0) begin
                        tbl_len[lft] = fhsa_pkg::VW'(tbl_len[lft] + sz);
                    end else if (rgt >= 0) begin
                        tbl_base[rgt] = fhsa_pkg::VW'(b);
                        tbl_len[rgt] = fhsa_pkg::VW'(tbl_len[rgt] + sz);
                    end else if (tbl_cnt >= NHOLES) begin
                        r.status = fhsa_pkg::STS_OVF;
                    end else begin
                        pos = 0;
                        while (pos < tbl_cnt && tbl_base[pos] <= b) pos++;
                        for (int unsigned i = tbl_cnt; i > pos; i--) begin
                            tbl_base[i] = tbl_base[i-1];
                            tbl_len[i] = tbl_len[i-1];
                        end
                        tbl_base[pos] = fhsa_pkg::VW'(b);
                        tbl_len[pos] = fhsa_pkg::VW'(sz);
                        tbl_cnt++;
                    end
                end
            end
            fhsa_pkg::ACT_COMPACT: begin
                f = free_total();
                b = (f <= mdl_mem) ? (mdl_mem - f) : 0;
                for (int i = 0; i < NHOLES; i++) begin
                    tbl_base[i] = '0;
                    tbl_len[i] = '0;
                end
                if (f == 0) begin
                    tbl_cnt = 0;
                end else begin
                    tbl_base[0] = fhsa_pkg::VW'(b);
                    tbl_len[0] = fhsa_pkg::VW'(f);
                    tbl_cnt = 1;
                end
                r.result_base = fhsa_pkg::VW'(b);
            end
            default: ;
        endcase
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: one beat at a time from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            expected_rsp.push_back(apply_request(i_req));
            if (pending_req.size() != 0 && !(gaps_on && $urandom_range(99) < 18)) begin
                i_req <= pending_req.pop_front();
            end else begin
                start <= 1'b0;
            end
        end else if (!start && pending_req.size() != 0
                && !(gaps_on && $urandom_range(99) < 18)) begin
            i_req <= pending_req.pop_front();
            start <= 1'b1;
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        fhsa_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected result status=%0d base=%0d", $time,
                         o_rsp.status, o_rsp.result_base);
                errors++;
            end else begin
                want = expected_rsp.pop_front();
                n_checked++;
                if (o_rsp.status !== want.status)
                    begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_rsp.status);
                    errors++;
                end
                if (o_rsp.result_base !== want.result_base) begin
                    $display("%0t: result_base expected %0d actual %0d", $time,
                             want.result_base, o_rsp.result_base);
                    errors++;
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic fhsa_pkg::t_req make_req(logic [1:0] act, longint unsigned b,
                                                longint unsigned s);
        fhsa_pkg::t_req rq;
        rq.action = act;
        rq.seg_base = fhsa_pkg::AW'(b);
        rq.seg_size = fhsa_pkg::VW'(s);
        return rq;
    endfunction

    task automatic wait_drained();
        while (pending_req.size() != 0 || start || busy || expected_rsp.size() != 0)
            @(posedge i_clk);
        repeat (2 * NHOLES + 12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [fhsa_pkg::CFG_IDX_W-1:0] idx,
                             logic [fhsa_pkg::VW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            fhsa_pkg::CFG_POLICY: mdl_policy = val[1:0];
            fhsa_pkg::CFG_MEM_SIZE: begin mdl_mem = val; rebuild_table(); end
            fhsa_pkg::CFG_RSV_SIZE: begin mdl_rsv = val; rebuild_table(); end
            default: ;
        endcase
        repeat (3) @(posedge i_clk);
    endtask

    // one random request, mostly well formed against the current region
    function automatic fhsa_pkg::t_req rand_req();
        int unsigned k;
        longint unsigned span;
        k = $urandom_range(99);
        span = (mdl_mem > mdl_rsv) ? (mdl_mem - mdl_rsv) : 64;
        if (k < 3) return make_req(ACT_UNKNOWN, $urandom, $urandom);
        if (k < 6) return make_req(fhsa_pkg::ACT_COMPACT, $urandom, $urandom);
        if (k < 10) return make_req(2'($urandom_range(1, 0)), $urandom,
                                    $urandom & 21'h1fffff);
        if (k < 55) return make_req(fhsa_pkg::ACT_ALLOC, 0, $urandom_range(span / 8 + 1, 0));
        return make_req(fhsa_pkg::ACT_RELEASE, mdl_rsv + $urandom_range(span, 0) & 20'hfffff,
                        $urandom_range(span / 16 + 1, 0));
    endfunction

    initial begin
        int unsigned phase_cfg [6][3];
        errors = 0;
        n_checked = 0;
        cycles = 0;
        gaps_on = 1'b1;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = fhsa_pkg::CFG_POLICY;
        i_cfg_data = '0;
        mdl_policy = fhsa_pkg::POL_FIRST;
        mdl_mem = fhsa_pkg::MEM_SIZE_RST;
        mdl_rsv = fhsa_pkg::RSV_SIZE_RST;
        rebuild_table();
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats on the reset region
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 0));
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 100));
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 200));
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 300));
        pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 128, 100));
        pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 428, 300));
        pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 228, 200));
        pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 5000, 0));
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 21'h100000));
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 21'h1fffff));
        pending_req.push_back(make_req(ACT_UNKNOWN, 20'hfffff, 21'h1fffff));
        pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 20'hfffff, 21'h1fffff));
        pending_req.push_back(make_req(fhsa_pkg::ACT_COMPACT, 0, 0));
        // fill the table with isolated holes to reach overflow
        for (int i = 0; i < 34; i++)
            pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 20000 + 16 * i, 4));
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 5000));
        pending_req.push_back(make_req(fhsa_pkg::ACT_COMPACT, 0, 0));
        wait_drained();

        // empty table: zero allocate and compact with no free space
        write_reg(fhsa_pkg::CFG_RSV_SIZE, 21'd4096);
        pending_req.push_back(make_req(fhsa_pkg::ACT_ALLOC, 0, 0));
        pending_req.push_back(make_req(fhsa_pkg::ACT_COMPACT, 0, 0));
        pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 0, 21'h1fffff));
        pending_req.push_back(make_req(fhsa_pkg::ACT_RELEASE, 20'hfffff, 21'h1fffff));
        pending_req.push_back(make_req(fhsa_pkg::ACT_COMPACT, 0, 0));
        wait_drained();

        // random phases through policy and region settings
        phase_cfg = '{'{0, 4096, 128}, '{1, 1048576, 0}, '{2, 8192, 1024},
                      '{3, 2048, 2048}, '{1, 1048576, 1048576}, '{2, 65536, 0}};
        for (int p = 0; p < 6; p++) begin
            write_reg(fhsa_pkg::CFG_POLICY, fhsa_pkg::VW'(phase_cfg[p][0]));
            write_reg(fhsa_pkg::CFG_MEM_SIZE, fhsa_pkg::VW'(phase_cfg[p][1]));
            write_reg(fhsa_pkg::CFG_RSV_SIZE, fhsa_pkg::VW'(phase_cfg[p][2]));
            gaps_on = (p != 2);
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                pending_req.push_back(rand_req());
                if (i == 100) begin
                    // let the block run dry before continuing
                    wait_drained();
                end
                if (pending_req.size() > 8) @(posedge i_clk);
                while (pending_req.size() > 8) @(posedge i_clk);
            end
            wait_drained();
        end

        $display("checked %0d result beats over six policy and region settings", n_checked);
        $display("covered allocate, release, compact, merges, overflow and idle beats");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
